>>> src/nclu_pkg.sv
package nclu_pkg;

	// Defaults for the top-level parameters.
	localparam int CENTER_COUNT_DEF = 64;
	localparam int COORD_BITS_DEF   = 16;

	// Fixed field widths of the item ports.
	localparam int ENTRY_W    = 6;
	localparam int POINT_W    = 16;
	localparam int DIST_OUT_W = 33;

	// Operation codes carried in the opcode field.
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Sequencer states, one-hot.
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	// Control that travels alongside each center sample into the search unit.
	typedef struct packed {
		logic valid;
		logic last;
	} tag_t;

endpackage

>>> src/nearest_center_lookup_unit.sv
// Channel   Direction  Handshake            Fields
// in        into block in_valid / in_stall   opcode, entry_index, point_x, point_y
// out       from block out_valid / out_stall nearest_index, nearest_distance_sq
//
// A load item writes one cell of the ring; it gives no result. In a query the ring of
// cells rotates once past the single distance unit, which adds two pipeline stages and
// a final update.
// The input is stalled from a query's acceptance until its result enters the output
// register; a result that waits on out_stall blocks only the next query's hand-over.
// Reset clears the sequencer and the output valid; the center cells are not cleared.
module nearest_center_lookup_unit import nclu_pkg::*; #(
	parameter int CENTER_COUNT = CENTER_COUNT_DEF,
	parameter int COORD_BITS   = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  opcode,
	input  logic [ENTRY_W-1:0]    entry_index,
	input  logic [POINT_W-1:0]    point_x,
	input  logic [POINT_W-1:0]    point_y,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [ENTRY_W-1:0]    nearest_index,
	output logic [DIST_OUT_W-1:0] nearest_distance_sq
);

	// Index width of the table, kept at one bit for a single-entry table.
	localparam int IDX_W  = (CENTER_COUNT > 1) ? $clog2(CENTER_COUNT) : 1;
	// Width at which the incoming slot number is matched against cell positions.
	localparam int SEL_W  = (IDX_W > ENTRY_W) ? IDX_W : ENTRY_W;
	localparam int DIST_W = 2 * COORD_BITS + 1;

	state_t                state_q;
	logic [IDX_W-1:0]      cnt_q;
	logic                  cnt_last;
	logic                  in_acc;
	logic                  load_acc;
	logic                  query_acc;
	logic [COORD_BITS-1:0] px;
	logic [COORD_BITS-1:0] py;
	logic [COORD_BITS-1:0] qx_q;
	logic [COORD_BITS-1:0] qy_q;
	logic [SEL_W-1:0]      entry_sel;
	logic                  shift_en;

	logic [COORD_BITS-1:0] cell_x [CENTER_COUNT];
	logic [COORD_BITS-1:0] cell_y [CENTER_COUNT];

	tag_t                  feed_tag;
	logic                  search_done;
	logic [IDX_W-1:0]      best_idx;
	logic [DIST_W-1:0]     best_dist;

	logic                  out_valid_q;
	logic [ENTRY_W-1:0]    out_idx_q;
	logic [DIST_OUT_W-1:0] out_dist_q;
	logic                  out_load;

	// Items are taken only while the sequencer is idle, so a load never lands
	// in the ring while it is rotated away from its home positions.
	assign in_stall  = !(state_q == ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign load_acc  = in_acc && (opcode == OP_LOAD);
	assign query_acc = in_acc && (opcode == OP_QUERY);

	// Coordinates are used in their low COORD_BITS bits.
	assign px        = COORD_BITS'(point_x);
	assign py        = COORD_BITS'(point_y);
	assign entry_sel = SEL_W'(entry_index);

	assign shift_en  = (state_q == ST_SCAN);
	assign cnt_last  = (cnt_q == IDX_W'(CENTER_COUNT - 1));

	// The ring: cell k takes the center of cell k+1, and the last cell takes
	// cell zero's, so after CENTER_COUNT shifts every center is back home.
	// Cell zero always presents the center whose index the scan counter holds.
	for (genvar k = 0; k < CENTER_COUNT; k++) begin : g_cell
		nclu_cell #(
			.COORD_BITS(COORD_BITS)
		) u_cell (
			.clk      (clk),
			.ld_en    (load_acc && (entry_sel == SEL_W'(k))),
			.ld_x     (px),
			.ld_y     (py),
			.shift_en (shift_en),
			.nb_x     (cell_x[(k + 1) % CENTER_COUNT]),
			.nb_y     (cell_y[(k + 1) % CENTER_COUNT]),
			.x        (cell_x[k]),
			.y        (cell_y[k])
		);
	end

	// The query point is held for the whole scan.
	always_ff @(posedge clk) begin
		if (query_acc) begin
			qx_q <= px;
			qy_q <= py;
		end
	end

	// Sequencer: idle, rotate the ring once, wait for the last sample to leave
	// the distance pipeline, then hand the winner to the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (query_acc) begin
						state_q <= ST_SCAN;
						cnt_q   <= '0;
					end
				end
				ST_SCAN: begin
					if (cnt_last) begin
						state_q <= ST_DRAIN;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					if (search_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					cnt_q   <= '0;
				end
			endcase
		end
	end

	assign feed_tag.valid = shift_en;
	assign feed_tag.last  = shift_en && cnt_last;

	nclu_search #(
		.COORD_BITS(COORD_BITS),
		.IDX_W     (IDX_W)
	) u_search (
		.clk       (clk),
		.arst_n    (arst_n),
		.feed_tag  (feed_tag),
		.feed_idx  (cnt_q),
		.qx        (qx_q),
		.qy        (qy_q),
		.cx        (cell_x[0]),
		.cy        (cell_y[0]),
		.done      (search_done),
		.best_idx  (best_idx),
		.best_dist (best_dist)
	);

	// Output register: filled from the search result once any earlier result
	// has been taken or is being taken in this cycle.
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_idx_q  <= ENTRY_W'(best_idx);
			out_dist_q <= DIST_OUT_W'(best_dist);
		end
	end

	assign out_valid           = out_valid_q;
	assign nearest_index       = out_idx_q;
	assign nearest_distance_sq = out_dist_q;

	// A new result only ever comes from a finished search.
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_DONE))
		else $error("result raised without a finished search");

	// The ring must be home, with the counter cleared, whenever items are taken.
	a_idle_home: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (cnt_q == '0))
		else $error("scan counter not home while idle");

	// The last sample leaves the distance pipeline only while draining.
	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		search_done |-> (state_q == ST_DRAIN))
		else $error("search finished outside the drain state");

	// A scan always ends after exactly one pass, entering the drain state next.
	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(shift_en && cnt_last) |=> (state_q == ST_DRAIN))
		else $error("scan did not stop after the last center");

endmodule

>>> src/nclu_cell.sv
module nclu_cell import nclu_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  ld_en,
	input  logic [COORD_BITS-1:0] ld_x,
	input  logic [COORD_BITS-1:0] ld_y,
	input  logic                  shift_en,
	input  logic [COORD_BITS-1:0] nb_x,
	input  logic [COORD_BITS-1:0] nb_y,
	output logic [COORD_BITS-1:0] x,
	output logic [COORD_BITS-1:0] y
);

	logic [COORD_BITS-1:0] x_q;
	logic [COORD_BITS-1:0] y_q;

	// A cell either takes a new center from a load or passes its neighbour's
	// center along the ring while a query is scanning; otherwise it holds its center.
	always_ff @(posedge clk) begin
		priority if (ld_en) begin
			x_q <= ld_x;
			y_q <= ld_y;
		end else if (shift_en) begin
			x_q <= nb_x;
			y_q <= nb_y;
		end else begin
			x_q <= x_q;
			y_q <= y_q;
		end
	end

	assign x = x_q;
	assign y = y_q;

endmodule

>>> src/nclu_search.sv
module nclu_search import nclu_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int IDX_W = 6,
	localparam int DIST_W = 2 * COORD_BITS + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tag_t                  feed_tag,
	input  logic [IDX_W-1:0]      feed_idx,
	input  logic [COORD_BITS-1:0] qx,
	input  logic [COORD_BITS-1:0] qy,
	input  logic [COORD_BITS-1:0] cx,
	input  logic [COORD_BITS-1:0] cy,
	output logic                  done,
	output logic [IDX_W-1:0]      best_idx,
	output logic [DIST_W-1:0]     best_dist
);

	localparam int SQ_W = 2 * COORD_BITS;

	tag_t                  tag_s1;
	tag_t                  tag_s2;
	logic [IDX_W-1:0]      idx_s1;
	logic [IDX_W-1:0]      idx_s2;
	logic [COORD_BITS-1:0] dx_s1;
	logic [COORD_BITS-1:0] dy_s1;
	logic [SQ_W-1:0]       sqx_s2;
	logic [SQ_W-1:0]       sqy_s2;
	logic [DIST_W-1:0]     dist_sum;
	logic [IDX_W-1:0]      best_idx_q;
	logic [DIST_W-1:0]     best_dist_q;
	logic                  take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			tag_s1 <= feed_tag;
			tag_s2 <= tag_s1;
		end
	end

	// Stage one: absolute coordinate differences.
	always_ff @(posedge clk) begin
		idx_s1 <= feed_idx;
		dx_s1  <= (qx >= cx) ? (qx - cx) : (cx - qx);
		dy_s1  <= (qy >= cy) ? (qy - cy) : (cy - qy);
	end

	// Stage two: one square per axis.
	always_ff @(posedge clk) begin
		idx_s2 <= idx_s1;
		sqx_s2 <= SQ_W'(dx_s1) * SQ_W'(dx_s1);
		sqy_s2 <= SQ_W'(dy_s1) * SQ_W'(dy_s1);
	end

	assign dist_sum = DIST_W'(sqx_s2) + DIST_W'(sqy_s2);

	// Entry zero always opens the search; afterwards only a strictly smaller
	// distance replaces the candidate, so ties keep the lower index.
	assign take = tag_s2.valid && ((idx_s2 == '0) || (dist_sum < best_dist_q));

	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q  <= idx_s2;
			best_dist_q <= dist_sum;
		end
	end

	assign done      = tag_s2.valid && tag_s2.last;
	assign best_idx  = best_idx_q;
	assign best_dist = best_dist_q;

endmodule

>>> test/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import nclu_pkg::*;

	// Size of the center table as built, and the timing figures of the run.
	localparam int CENTERS        = CENTER_COUNT_DEF;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 100;

	// One expected answer of the block: the winning slot and its squared distance.
	typedef struct packed {
		logic [ENTRY_W-1:0]    index;
		logic [DIST_OUT_W-1:0] dist_sq;
	} nearest_t;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  in_valid    = 1'b0;
	logic                  in_stall;
	logic                  opcode      = OP_LOAD;
	logic [ENTRY_W-1:0]    entry_index = '0;
	logic [POINT_W-1:0]    point_x     = '0;
	logic [POINT_W-1:0]    point_y     = '0;
	logic                  out_valid;
	logic                  out_stall   = 1'b0;
	logic [ENTRY_W-1:0]    nearest_index;
	logic [DIST_OUT_W-1:0] nearest_distance_sq;

	// The testbench's own copy of the center table, kept in step with every accepted load.
	logic [POINT_W-1:0] center_x [CENTERS];
	logic [POINT_W-1:0] center_y [CENTERS];

	// Answers that queries have earned and that the block still owes, oldest first.
	nearest_t pending_nearest [$];
	nearest_t oldest;

	// Random idling on both channels is switched off for the last part of the run, and
	// hold_request asks the receiving process for one long hold-off of the output.
	bit idling       = 1'b1;
	bit hold_request = 1'b0;

	int loads_sent      = 0;
	int queries_sent    = 0;
	int tie_queries     = 0;
	int results_checked = 0;
	int mismatches      = 0;
	int quiet_cycles    = 0;

	nearest_center_lookup_unit i_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.opcode              (opcode),
		.entry_index         (entry_index),
		.point_x             (point_x),
		.point_y             (point_y),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.nearest_index       (nearest_index),
		.nearest_distance_sq (nearest_distance_sq)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Scans the table in slot order and keeps the first slot that is strictly nearer than
	// everything before it, so slot 0 always starts the search and equal distances leave
	// the lower slot in place. The tie flag tells whether any later slot matched the best.
	function automatic nearest_t nearest_center_of(input logic [POINT_W-1:0] px,
			input logic [POINT_W-1:0] py, output bit tie);
		nearest_t           best;
		logic [POINT_W-1:0] dx;
		logic [POINT_W-1:0] dy;
		logic [63:0]        dist_now;
		best = '0;
		tie  = 1'b0;
		for (int i = 0; i < CENTERS; i++) begin
			dx       = (px >= center_x[i]) ? px - center_x[i] : center_x[i] - px;
			dy       = (py >= center_y[i]) ? py - center_y[i] : center_y[i] - py;
			dist_now = 64'(dx) * 64'(dx) + 64'(dy) * 64'(dy);
			if (i == 0 || dist_now < 64'(best.dist_sq)) begin
				best.index   = ENTRY_W'(i);
				best.dist_sq = dist_now[DIST_OUT_W-1:0];
				tie          = 1'b0;
			end else if (dist_now == 64'(best.dist_sq)) begin
				tie = 1'b1;
			end
		end
		return best;
	endfunction

	// Coordinates are drawn from a handful of shapes: anywhere in the range, a tiny corner
	// where equal distances are common, the two ends of the range and the middle.
	function automatic logic [POINT_W-1:0] pick_coord();
		case ($urandom_range(0, 5))
			0, 1: begin
				return POINT_W'($urandom_range(0, 16'hFFFF));
			end
			2: begin
				return POINT_W'($urandom_range(0, 7));
			end
			3: begin
				return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			end
			4: begin
				return 16'hFFFF - POINT_W'($urandom_range(0, 7));
			end
			default: begin
				return 16'h7FF8 + POINT_W'($urandom_range(0, 15));
			end
		endcase
	endfunction

	// Offers one item, now and then after a short gap, holds it steady until the block
	// takes it, and then brings the local table or the queue of answers up to date.
	// The valid stays high on return so that back-to-back items need no extra step;
	// whoever stops sending lowers it at the next falling edge.
	task automatic send_item(input logic op, input logic [ENTRY_W-1:0] slot,
			input logic [POINT_W-1:0] px, input logic [POINT_W-1:0] py);
		int       gap;
		bit       tie;
		nearest_t expected;
		gap = (idling && $urandom_range(0, 4) == 0) ? $urandom_range(1, 14) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		entry_index <= slot;
		point_x     <= px;
		point_y     <= py;
		do @(posedge clk); while (in_stall);
		if (op == OP_LOAD) begin
			center_x[slot] = px;
			center_y[slot] = py;
			loads_sent++;
		end else begin
			expected = nearest_center_of(px, py, tie);
			pending_nearest.push_back(expected);
			queries_sent++;
			if (tie) begin
				tie_queries++;
			end
		end
	endtask

	// Takes the input valid down and waits until every answer owed has come out.
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_nearest.size() != 0) @(posedge clk);
	endtask

	// Rewrites every slot in order, either at one shared point or at random points.
	task automatic fill_table(input bit same_point);
		for (int i = 0; i < CENTERS; i++) begin
			if (same_point) begin
				send_item(OP_LOAD, ENTRY_W'(i), '0, '0);
			end else begin
				send_item(OP_LOAD, ENTRY_W'(i), pick_coord(), pick_coord());
			end
		end
	endtask

	// Mostly queries, with loads mixed in that keep moving the centers about. Queries go
	// to random points, to a stored center exactly, or to a point a little way from one.
	// Every couple of hundred items the whole table is rewritten.
	task automatic run_random_items(input int count);
		logic [ENTRY_W-1:0] slot;
		int                 near;
		for (int n = 0; n < count; n++) begin
			if (n % 200 == 199) begin
				fill_table(1'b0);
			end
			slot = ENTRY_W'($urandom_range(0, CENTERS - 1));
			near = $urandom_range(0, CENTERS - 1);
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					send_item(OP_LOAD, slot, pick_coord(), pick_coord());
				end
				3, 4, 5: begin
					send_item(OP_QUERY, slot, pick_coord(), pick_coord());
				end
				6, 7: begin
					send_item(OP_QUERY, slot, center_x[near], center_y[near]);
				end
				default: begin
					send_item(OP_QUERY, slot,
						center_x[near] ^ POINT_W'($urandom_range(0, 3)),
						center_y[near] ^ POINT_W'($urandom_range(0, 3)));
				end
			endcase
		end
	endtask

	// The extremes of the coordinates, a query that ignores a nonzero entry_index, the
	// first slot taken even at the largest possible distance, and equal distances where
	// the lower slot has to win.
	task automatic test_directed_extremes();
		fill_table(1'b1);
		// Every center is at the origin and equally far away, at the largest distance.
		send_item(OP_QUERY, '0, 16'hFFFF, 16'hFFFF);
		send_item(OP_QUERY, 6'h3F, 16'h0000, 16'h0000);
		send_item(OP_LOAD, 6'd63, 16'hFFFF, 16'hFFFF);
		send_item(OP_QUERY, 6'h2A, 16'hFFFF, 16'hFFFF);
		// Slots 40 and 63 now sit at the same point, so 40 must be named.
		send_item(OP_LOAD, 6'd40, 16'hFFFF, 16'hFFFF);
		send_item(OP_QUERY, '0, 16'hFFFF, 16'hFFFE);
		send_item(OP_LOAD, 6'd0, 16'hFFFF, 16'h0000);
		send_item(OP_LOAD, 6'd1, 16'h0000, 16'hFFFF);
		send_item(OP_QUERY, 6'h15, 16'hFFFF, 16'h0000);
		send_item(OP_QUERY, '0, 16'h0000, 16'hFFFF);
		send_item(OP_QUERY, '0, 16'h8000, 16'h8000);
		send_item(OP_QUERY, '0, 16'h7FFF, 16'h8000);
		// Overwriting a slot must replace the old point, not add to it.
		send_item(OP_LOAD, 6'd63, 16'h8000, 16'h7FFF);
		send_item(OP_QUERY, '0, 16'h8000, 16'h8000);
		send_item(OP_QUERY, '0, 16'h0001, 16'hFFFE);
		wait_drained();
	endtask

	// The receiver holds the output off for a long while as a run of queries arrives, so
	// a finished answer waits in the output register, the next one queues up behind it
	// and the block has to stall its input until the hold is over.
	task automatic test_output_hold();
		hold_request = 1'b1;
		for (int n = 0; n < 6; n++) begin
			send_item(OP_QUERY, ENTRY_W'($urandom_range(0, CENTERS - 1)),
				pick_coord(), pick_coord());
		end
		wait_drained();
	endtask

	// The bulk of the run: a random table with random loads and queries, idling on.
	task automatic test_random_mix();
		fill_table(1'b0);
		run_random_items(450);
		wait_drained();
	endtask

	// The last part: no idling on either side, so items follow one another as fast as
	// the block allows.
	task automatic test_steady_stream();
		idling = 1'b0;
		run_random_items(150);
		wait_drained();
	endtask

	// The receiving side: it normally takes every result, now and then stalls for a random
	// burst, and once stalls for a long stretch when asked to.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_stall <= 1'b0;
			end else if (idling && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Every result taken off the output is matched with the oldest answer still owed.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_checked++;
			if (pending_nearest.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("tb: unexpected result, index %0d distance %0d",
						nearest_index, nearest_distance_sq);
				end
			end else begin
				oldest = pending_nearest.pop_front();
				if (nearest_index !== oldest.index || nearest_distance_sq !== oldest.dist_sq)
				begin
					mismatches++;
					if (mismatches <= 10) begin
						$display({"tb: result %0d: expected index %0d distance %0d, ",
							"got index %0d distance %0d"},
							results_checked, oldest.index, oldest.dist_sq,
							nearest_index, nearest_distance_sq);
					end
				end
			end
		end
	end

	// The run is stopped if neither channel moves an item for too long. The limit covers
	// the long output hold plus a full scan several times over.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: no item moved for %0d cycles, giving up", quiet_cycles);
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_extremes();
		test_output_hold();
		test_random_mix();
		test_steady_stream();

		// Give the block a scan's worth of time to show any result that nobody asked for.
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("tb: %0d loads and %0d queries sent, %0d results checked, %0d mismatches",
			loads_sent, queries_sent, results_checked, mismatches);
		$display("tb: %0d queries met equally near centers; one long output hold was applied",
			tie_queries);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
